/* rtl/bwlp_pkg.sv */
// Shared constants and types of the Butterworth low-pass mask generator.
package bwlp_pkg;

   localparam int MAX_DIM          = 4096;
   localparam int WEIGHT_FRAC_BITS = 16;

   localparam int DIM_W    = $clog2(MAX_DIM) + 1;      // mask size, holds MAX_DIM
   localparam int IDX_W    = 12;                       // row/col index, also offset width
   localparam int SQ_W     = 2 * DIM_W - 1;            // size squared
   localparam int Q_W      = 31;                       // quotient bits of the radius divides
   localparam int QNUM_W   = 2 * IDX_W + 32;           // radius dividend
   localparam int R2_W     = Q_W + 1;                  // r squared, Q.32
   localparam int CUT_W    = 16;
   localparam int CUT_MAX  = 32768;
   localparam int CUTSQ_W  = 2 * CUT_W - 1;
   localparam int P_W      = WEIGHT_FRAC_BITS + 34;    // power values, holds saturation
   localparam int PH_W     = P_W - 32;                 // integer part of a power value
   localparam int UNUM_W   = R2_W + 32;                // dividend of u
   localparam int THR_W    = CUTSQ_W + P_W;
   localparam int W_W      = WEIGHT_FRAC_BITS + 1;
   localparam int ORD_W    = 5;
   localparam int ORD_MAX  = 16;
   localparam int STEP_W   = 4;
   localparam int MAX_STEPS = ORD_MAX - 1;
   localparam int ZSUM_W   = 2 * PH_W + 34;

   localparam logic [P_W-1:0] SAT_Q32 = P_W'(1) << (P_W - 1);
   localparam logic [P_W-1:0] ONE_Q32 = P_W'(1) << 32;
   localparam logic [W_W-1:0] W_ONE   = W_W'(1) << WEIGHT_FRAC_BITS;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_ROWS       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_COLS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF_FRACTION = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ORDER    = 2'd3;

   typedef struct packed {
      logic [DIM_W-1:0]   row_even;
      logic [DIM_W-1:0]   col_even;
      logic [SQ_W-1:0]    rows_sq;
      logic [SQ_W-1:0]    cols_sq;
      logic [CUTSQ_W-1:0] cut_sq;
      logic [THR_W-1:0]   sat_thr;
      logic [STEP_W-1:0]  pw_steps;
   } cfg_type;

endpackage

/* rtl/butterworth_lowpass_mask_gen.sv */
// Top level of the Butterworth low-pass frequency mask generator.
//
// Takes one mask position (row, column) per cycle and returns its Butterworth
// low-pass weight, already quadrant-swapped and cropped to even size, in Q1.16.
// The pipeline is 150 register stages deep, and a new item may enter at every
// edge. The depth comes from the bit-per-stage dividers (31 stages for the
// normalized radius, 50 for r^2/cutoff^2, 17 for the final reciprocal) and from
// the 15 saturating multiply steps of three stages each for the power. A stall
// on rsp_ freezes the whole pipeline. Configuration registers may be written
// only while no item is in flight.
module butterworth_lowpass_mask_gen (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bwlp_pkg::IDX_W-1:0]       req_row_index,
   input  logic [bwlp_pkg::IDX_W-1:0]       req_col_index,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bwlp_pkg::W_W-1:0]         rsp_weight,
   output logic                             rsp_outside_mask,
   input  logic                             csr_wr_en,
   input  logic [bwlp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bwlp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bwlp_pkg::*;

   logic [DIM_W-1:0] mask_rows_ff, mask_cols_ff;
   logic [CUT_W-1:0] cutoff_fraction_ff;
   logic [ORD_W-1:0] filter_order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_rows_ff       <= DIM_W'(256);
         mask_cols_ff       <= DIM_W'(256);
         cutoff_fraction_ff <= CUT_W'(29491);
         filter_order_ff    <= ORD_W'(15);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MASK_ROWS:       mask_rows_ff       <= csr_data[DIM_W-1:0];
            CSR_MASK_COLS:       mask_cols_ff       <= csr_data[DIM_W-1:0];
            CSR_CUTOFF_FRACTION: cutoff_fraction_ff <= csr_data[CUT_W-1:0];
            CSR_FILTER_ORDER:    filter_order_ff    <= csr_data[ORD_W-1:0];
            default: ;
         endcase
      end
   end

   // derived settings, which the user must keep static while items are in flight; the block itself does not enforce it
   cfg_type          cfg_ff, cfg_in;
   logic [DIM_W-1:0] rows_c, cols_c;
   logic [CUT_W-1:0] cut_c;
   logic [ORD_W-1:0] ord_c;

   always_comb begin
      if (mask_rows_ff < DIM_W'(2))            rows_c = DIM_W'(2);
      else if (mask_rows_ff > DIM_W'(MAX_DIM)) rows_c = DIM_W'(MAX_DIM);
      else                                     rows_c = mask_rows_ff;
      if (mask_cols_ff < DIM_W'(2))            cols_c = DIM_W'(2);
      else if (mask_cols_ff > DIM_W'(MAX_DIM)) cols_c = DIM_W'(MAX_DIM);
      else                                     cols_c = mask_cols_ff;
      if (cutoff_fraction_ff == '0)                  cut_c = CUT_W'(1);
      else if (cutoff_fraction_ff > CUT_W'(CUT_MAX)) cut_c = CUT_W'(CUT_MAX);
      else                                           cut_c = cutoff_fraction_ff;
      if (filter_order_ff == '0)                  ord_c = ORD_W'(1);
      else if (filter_order_ff > ORD_W'(ORD_MAX)) ord_c = ORD_W'(ORD_MAX);
      else                                        ord_c = filter_order_ff;

      cfg_in.row_even = {rows_c[DIM_W-1:1], 1'b0};
      cfg_in.col_even = {cols_c[DIM_W-1:1], 1'b0};
      cfg_in.rows_sq  = SQ_W'(rows_c * rows_c);
      cfg_in.cols_sq  = SQ_W'(cols_c * cols_c);
      cfg_in.cut_sq   = CUTSQ_W'(cut_c * cut_c);
      // u saturates once r2 * 2^32 + cut^2/2 reaches (S + 1) * cut^2
      cfg_in.sat_thr  = (THR_W'(cfg_in.cut_sq) << (P_W - 1)) + THR_W'(cfg_in.cut_sq);
      cfg_in.pw_steps = STEP_W'(ord_c - ORD_W'(1));
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   // pipeline moves whenever the output register is free or being taken
   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   logic             rad_valid, rad_outside;
   logic [P_W-1:0]   rad_u;
   logic             pw_valid, pw_outside;
   logic [W_W-1:0]   pw_weight;

   bwlp_radius u_radius (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .cfg         (cfg_ff),
      .in_valid    (req_valid),
      .in_row      (req_row_index),
      .in_col      (req_col_index),
      .out_valid   (rad_valid),
      .out_u       (rad_u),
      .out_outside (rad_outside)
   );

   bwlp_power u_power (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .cfg         (cfg_ff),
      .in_valid    (rad_valid),
      .in_u        (rad_u),
      .in_outside  (rad_outside),
      .out_valid   (pw_valid),
      .out_weight  (pw_weight),
      .out_outside (pw_outside)
   );

   logic           rsp_valid_ff, rsp_outside_ff;
   logic [W_W-1:0] rsp_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= pw_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_weight_ff  <= pw_weight;
         rsp_outside_ff <= pw_outside;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_weight       = rsp_weight_ff;
   assign rsp_outside_mask = rsp_outside_ff;

endmodule

/* rtl/bwlp_radius.sv */
// Radius stages: swapped offsets, normalized r squared and u = r^2/cutoff^2.
module bwlp_radius (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  bwlp_pkg::cfg_type           cfg,
   input  logic                        in_valid,
   input  logic [bwlp_pkg::IDX_W-1:0]  in_row,
   input  logic [bwlp_pkg::IDX_W-1:0]  in_col,
   output logic                        out_valid,
   output logic [bwlp_pkg::P_W-1:0]    out_u,
   output logic                        out_outside
);
   import bwlp_pkg::*;

   // stage A: captured position
   logic             a_vld_ff;
   logic [IDX_W-1:0] a_row_ff, a_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_row_ff <= in_row;
         a_col_ff <= in_col;
      end
   end

   // stage B: outside flag and offset magnitudes after the quadrant swap
   logic             b_vld_ff, b_out_ff, b_out_in;
   logic [IDX_W-1:0] b_dy_ff, b_dx_ff, b_dy_in, b_dx_in;
   logic [IDX_W-1:0] half_r, half_c;

   always_comb begin
      half_r   = cfg.row_even[DIM_W-1:1];
      half_c   = cfg.col_even[DIM_W-1:1];
      b_out_in = ({1'b0, a_row_ff} >= cfg.row_even) || ({1'b0, a_col_ff} >= cfg.col_even);
      b_dy_in  = (a_row_ff < half_r) ? a_row_ff
                                     : IDX_W'(cfg.row_even - {1'b0, a_row_ff});
      b_dx_in  = (a_col_ff < half_c) ? a_col_ff
                                     : IDX_W'(cfg.col_even - {1'b0, a_col_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_out_ff <= b_out_in;
         b_dy_ff  <= b_dy_in;
         b_dx_ff  <= b_dx_in;
      end
   end

   // radius divides, one quotient bit per stage; the low word shifts out
   // dividend bits and shifts in quotient bits
   logic            qv_ff   [0:Q_W];
   logic            qo_ff   [0:Q_W];
   logic [SQ_W-1:0] yrem_ff [0:Q_W];
   logic [SQ_W-1:0] xrem_ff [0:Q_W];
   logic [Q_W-1:0]  ylow_ff [0:Q_W];
   logic [Q_W-1:0]  xlow_ff [0:Q_W];

   logic [2*IDX_W-1:0] y_sq, x_sq;
   logic [QNUM_W-1:0]  y_num, x_num;

   always_comb begin
      y_sq  = b_dy_ff * b_dy_ff;
      x_sq  = b_dx_ff * b_dx_ff;
      y_num = {y_sq, 32'd0} + QNUM_W'(cfg.rows_sq >> 1);
      x_num = {x_sq, 32'd0} + QNUM_W'(cfg.cols_sq >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff[0] <= 1'b0;
      end else if (en) begin
         qv_ff[0] <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qo_ff[0]   <= b_out_ff;
         yrem_ff[0] <= y_num[QNUM_W-1:Q_W];
         xrem_ff[0] <= x_num[QNUM_W-1:Q_W];
         ylow_ff[0] <= y_num[Q_W-1:0];
         xlow_ff[0] <= x_num[Q_W-1:0];
      end
   end

   for (genvar i = 0; i < Q_W; i++) begin : g_qdiv
      logic [SQ_W:0]   ty, tx;
      logic            gy, gx;
      logic [SQ_W-1:0] yrem_in, xrem_in;

      always_comb begin
         ty      = {yrem_ff[i], ylow_ff[i][Q_W-1]};
         tx      = {xrem_ff[i], xlow_ff[i][Q_W-1]};
         gy      = ty >= {1'b0, cfg.rows_sq};
         gx      = tx >= {1'b0, cfg.cols_sq};
         yrem_in = gy ? SQ_W'(ty - {1'b0, cfg.rows_sq}) : ty[SQ_W-1:0];
         xrem_in = gx ? SQ_W'(tx - {1'b0, cfg.cols_sq}) : tx[SQ_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            qv_ff[i+1] <= 1'b0;
         end else if (en) begin
            qv_ff[i+1] <= qv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            qo_ff[i+1]   <= qo_ff[i];
            yrem_ff[i+1] <= yrem_in;
            xrem_ff[i+1] <= xrem_in;
            ylow_ff[i+1] <= {ylow_ff[i][Q_W-2:0], gy};
            xlow_ff[i+1] <= {xlow_ff[i][Q_W-2:0], gx};
         end
      end
   end

   // u divide: r2 * 2^32 / cutoff^2, saturation decided up front
   logic               uv_ff   [0:P_W];
   logic               uo_ff   [0:P_W];
   logic               us_ff   [0:P_W];
   logic [CUTSQ_W-1:0] urem_ff [0:P_W];
   logic [P_W-1:0]     ulow_ff [0:P_W];

   logic [R2_W-1:0]   r2;
   logic [UNUM_W-1:0] u_num;
   logic              u_sat;

   always_comb begin
      r2    = {1'b0, ylow_ff[Q_W]} + {1'b0, xlow_ff[Q_W]};
      u_num = {r2, 32'd0} + UNUM_W'(cfg.cut_sq >> 1);
      u_sat = THR_W'(u_num) >= cfg.sat_thr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uv_ff[0] <= 1'b0;
      end else if (en) begin
         uv_ff[0] <= qv_ff[Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         uo_ff[0]   <= qo_ff[Q_W];
         us_ff[0]   <= u_sat;
         urem_ff[0] <= CUTSQ_W'(u_num[UNUM_W-1:P_W]);
         ulow_ff[0] <= u_num[P_W-1:0];
      end
   end

   for (genvar i = 0; i < P_W; i++) begin : g_udiv
      logic [CUTSQ_W:0]   t;
      logic               g;
      logic [CUTSQ_W-1:0] urem_in;

      always_comb begin
         t       = {urem_ff[i], ulow_ff[i][P_W-1]};
         g       = t >= {1'b0, cfg.cut_sq};
         urem_in = g ? CUTSQ_W'(t - {1'b0, cfg.cut_sq}) : t[CUTSQ_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            uv_ff[i+1] <= 1'b0;
         end else if (en) begin
            uv_ff[i+1] <= uv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            uo_ff[i+1]   <= uo_ff[i];
            us_ff[i+1]   <= us_ff[i];
            urem_ff[i+1] <= urem_in;
            ulow_ff[i+1] <= {ulow_ff[i][P_W-2:0], g};
         end
      end
   end

   assign out_valid   = uv_ff[P_W];
   assign out_outside = uo_ff[P_W];
   assign out_u       = us_ff[P_W] ? SAT_Q32 : ulow_ff[P_W];

endmodule

/* rtl/bwlp_power.sv */
// Power stages: u^n by repeated saturating Q.32 multiplies, then 1/(1+u^n).
module bwlp_power (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  bwlp_pkg::cfg_type          cfg,
   input  logic                       in_valid,
   input  logic [bwlp_pkg::P_W-1:0]   in_u,
   input  logic                       in_outside,
   output logic                       out_valid,
   output logic [bwlp_pkg::W_W-1:0]   out_weight,
   output logic                       out_outside
);
   import bwlp_pkg::*;

   // step boundaries; p starts as u (1.0 times u is exact)
   logic           sv_ff [0:MAX_STEPS];
   logic           so_ff [0:MAX_STEPS];
   logic [P_W-1:0] sp_ff [0:MAX_STEPS];
   logic [P_W-1:0] su_ff [0:MAX_STEPS-1];

   // partial products inside a step
   logic             xv_ff  [0:MAX_STEPS-1];
   logic             xo_ff  [0:MAX_STEPS-1];
   logic [P_W-1:0]   xp_ff  [0:MAX_STEPS-1];
   logic [P_W-1:0]   xu_ff  [0:MAX_STEPS-1];
   logic [63:0]      xm0_ff [0:MAX_STEPS-1];
   logic [P_W-1:0]   xm1_ff [0:MAX_STEPS-1];
   logic             yv_ff  [0:MAX_STEPS-1];
   logic             yo_ff  [0:MAX_STEPS-1];
   logic [P_W-1:0]   yp_ff  [0:MAX_STEPS-1];
   logic [P_W-1:0]   yu_ff  [0:MAX_STEPS-1];
   logic [P_W-1:0]   ym2_ff [0:MAX_STEPS-1];
   logic [2*PH_W-1:0] ym3_ff [0:MAX_STEPS-1];
   logic [P_W:0]     ys_ff  [0:MAX_STEPS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         so_ff[0] <= in_outside;
         sp_ff[0] <= in_u;
         su_ff[0] <= in_u;
      end
   end

   for (genvar k = 0; k < MAX_STEPS; k++) begin : g_step
      logic [63:0]       xm0_in;
      logic [P_W-1:0]    xm1_in;
      logic [32:0]       rnd_hi;
      logic [P_W:0]      ys_in;
      logic [P_W-1:0]    ym2_in;
      logic [2*PH_W-1:0] ym3_in;
      logic [ZSUM_W-1:0] tot;
      logic [P_W-1:0]    sp_in;
      logic              active;

      always_comb begin
         xm0_in = sp_ff[k][31:0] * su_ff[k][31:0];
         xm1_in = P_W'(sp_ff[k][P_W-1:32] * su_ff[k][31:0]);
      end

      always_comb begin
         ym2_in = P_W'(xp_ff[k][31:0] * xu_ff[k][P_W-1:32]);
         ym3_in = xp_ff[k][P_W-1:32] * xu_ff[k][P_W-1:32];
         rnd_hi = 33'(({1'b0, xm0_ff[k]} + 65'(32'h8000_0000)) >> 32);
         ys_in  = {1'b0, xm1_ff[k]} + (P_W+1)'(rnd_hi);
      end

      always_comb begin
         active = STEP_W'(k) < cfg.pw_steps;
         tot    = (ZSUM_W'(ym3_ff[k]) << 32) + ZSUM_W'(ym2_ff[k]) + ZSUM_W'(ys_ff[k]);
         if (!active) begin
            sp_in = yp_ff[k];
         end else if (tot >= ZSUM_W'(SAT_Q32)) begin
            sp_in = SAT_Q32;
         end else begin
            sp_in = tot[P_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            xv_ff[k]   <= 1'b0;
            yv_ff[k]   <= 1'b0;
            sv_ff[k+1] <= 1'b0;
         end else if (en) begin
            xv_ff[k]   <= sv_ff[k];
            yv_ff[k]   <= xv_ff[k];
            sv_ff[k+1] <= yv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            xo_ff[k]   <= so_ff[k];
            xp_ff[k]   <= sp_ff[k];
            xu_ff[k]   <= su_ff[k];
            xm0_ff[k]  <= xm0_in;
            xm1_ff[k]  <= xm1_in;
            yo_ff[k]   <= xo_ff[k];
            yp_ff[k]   <= xp_ff[k];
            yu_ff[k]   <= xu_ff[k];
            ym2_ff[k]  <= ym2_in;
            ym3_ff[k]  <= ym3_in;
            ys_ff[k]   <= ys_in;
            so_ff[k+1] <= yo_ff[k];
            sp_ff[k+1] <= sp_in;
         end
      end

      if (k + 1 < MAX_STEPS) begin : g_fwd
         always_ff @(posedge clock) begin
            if (en) begin
               su_ff[k+1] <= yu_ff[k];
            end
         end
      end
   end

   // weight = round(2^(F+32) / (2^32 + p)), one quotient bit per stage
   logic           wv_ff   [0:W_W];
   logic           wz_ff   [0:W_W];
   logic           wo_ff   [0:W_W];
   logic [P_W-1:0] wden_ff [0:W_W];
   logic [P_W-1:0] wrem_ff [0:W_W];
   logic [W_W-1:0] wlow_ff [0:W_W];

   logic [P_W-1:0] den, w_num;

   always_comb begin
      den   = ONE_Q32 + sp_ff[MAX_STEPS];
      w_num = (P_W'(1) << (WEIGHT_FRAC_BITS + 32)) + (den >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wv_ff[0] <= 1'b0;
      end else if (en) begin
         wv_ff[0] <= sv_ff[MAX_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wz_ff[0]   <= so_ff[MAX_STEPS] || (sp_ff[MAX_STEPS] >= SAT_Q32);
         wo_ff[0]   <= so_ff[MAX_STEPS];
         wden_ff[0] <= den;
         wrem_ff[0] <= P_W'(w_num[P_W-1:W_W]);
         wlow_ff[0] <= w_num[W_W-1:0];
      end
   end

   for (genvar i = 0; i < W_W; i++) begin : g_wdiv
      logic [P_W:0]   t;
      logic           g;
      logic [P_W-1:0] wrem_in;

      always_comb begin
         t       = {wrem_ff[i], wlow_ff[i][W_W-1]};
         g       = t >= {1'b0, wden_ff[i]};
         wrem_in = g ? P_W'(t - {1'b0, wden_ff[i]}) : t[P_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            wv_ff[i+1] <= 1'b0;
         end else if (en) begin
            wv_ff[i+1] <= wv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            wz_ff[i+1]   <= wz_ff[i];
            wo_ff[i+1]   <= wo_ff[i];
            wden_ff[i+1] <= wden_ff[i];
            wrem_ff[i+1] <= wrem_in;
            wlow_ff[i+1] <= {wlow_ff[i][W_W-2:0], g};
         end
      end
   end

   // outside positions carry the zero flag too
   logic out_zero;
   assign out_zero    = wz_ff[W_W];
   assign out_valid   = wv_ff[W_W];
   assign out_weight  = out_zero ? '0 : wlow_ff[W_W];
   assign out_outside = wo_ff[W_W];

endmodule

/* rtl/bwlp_checker.sv */
// Port-level assertions for the mask generator, bound to the top level.
module bwlp_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [bwlp_pkg::IDX_W-1:0]       req_row_index,
   input  logic [bwlp_pkg::IDX_W-1:0]       req_col_index,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [bwlp_pkg::W_W-1:0]         rsp_weight,
   input  logic                             rsp_outside_mask,
   input  logic                             csr_wr_en,
   input  logic [bwlp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bwlp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bwlp_pkg::*;

   // positions beyond the cropped size always read as zero weight
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outside_mask |-> rsp_weight == '0)
      else $error("outside item with nonzero weight");

   // a weight never exceeds 1.0
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weight <= W_ONE)
      else $error("weight above 1.0");

   // input is held back only by a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight)
                                 && $stable(rsp_outside_mask))
      else $error("stalled result changed");

endmodule

bind butterworth_lowpass_mask_gen bwlp_checker u_bwlp_checker (.*);
